>>> hw/rtl/nsfc_pkg.sv
package nsfc_pkg;

    localparam logic [7:0] C_MAX_LEN    = 8'd128;
    localparam logic [7:0] C_CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] C_CHAR_CR     = 8'h0D;
    localparam logic [7:0] C_CHAR_LF     = 8'h0A;
    localparam logic [7:0] C_CHAR_NINE   = 8'h39;
    localparam logic [7:0] C_CHAR_ZERO   = 8'h30;
    localparam logic [7:0] C_CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] C_CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] C_CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] C_CASE_OFFSET = 8'd32;
    localparam logic [7:0] C_HEX_TEN     = 8'd10;

    localparam logic [39:0] C_TAG_RESET  = 40'h4750524D43;
    localparam logic [7:0]  C_MAXLEN_RESET = 8'd128;

    localparam logic [7:0] C_MIN_LEN = 8'd3;
    localparam logic [7:0] C_TAG_LEN = 8'd6;

    typedef enum logic [1:0] {
        MODE_WAIT_DOLLAR = 2'd0,
        MODE_COLLECT     = 2'd1,
        MODE_WAIT_LF     = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        ST_RMC_OK         = 3'd0,
        ST_CHECKSUM_ERROR = 3'd1,
        ST_NOT_RMC        = 3'd2,
        ST_MISSING_LF     = 3'd3,
        ST_OVERFLOW       = 3'd4,
        ST_TOO_SHORT      = 3'd5
    } t_status;

    typedef enum logic {
        REG_SENTENCE_TAG = 1'b0,
        REG_MAX_LENGTH   = 1'b1
    } t_reg_index;

    typedef struct packed {
        logic [7:0] data;
        logic       is_dollar;
        logic       is_cr;
        logic       is_lf;
    } t_token;

    typedef struct packed {
        t_status    status;
        logic [7:0] sentence_length;
        logic [7:0] computed_checksum;
        logic [7:0] received_checksum;
    } t_result;

    function automatic logic [7:0] hex_digit(input logic [7:0] c);
        logic [7:0] u;
        u = c;
        if (c <= C_CHAR_NINE) begin
            return c - C_CHAR_ZERO;
        end
        if (c >= C_CHAR_LOWER_A && c <= C_CHAR_LOWER_Z) begin
            u = c - C_CASE_OFFSET;
        end
        return u - C_CHAR_UPPER_A + C_HEX_TEN;
    endfunction

endpackage

>>> hw/rtl/nsfc_fifo.sv
module nsfc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            // wrap at the last entry so any depth works
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end

endmodule

>>> hw/rtl/nsfc_front.sv
module nsfc_front import nsfc_pkg::*; (
    input  logic       i_push,
    input  logic [7:0] i_rx_byte,
    input  logic       i_queue_full,
    output logic       o_queue_push,
    output t_token     o_token
);

    // classify each byte once so the framer need not decode dollar, CR and LF itself
    assign o_queue_push      = i_push && !i_queue_full;
    assign o_token.data      = i_rx_byte;
    assign o_token.is_dollar = (i_rx_byte == C_CHAR_DOLLAR);
    assign o_token.is_cr     = (i_rx_byte == C_CHAR_CR);
    assign o_token.is_lf     = (i_rx_byte == C_CHAR_LF);

endmodule

>>> hw/rtl/nsfc_back.sv
module nsfc_back import nsfc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tok_valid,
    input  t_token      i_tok,
    output logic        o_tok_pop,
    input  logic        i_res_full,
    output logic        o_res_push,
    output t_result     o_res,
    input  logic [39:0] i_sentence_tag,
    input  logic [7:0]  i_max_length
);

    t_mode      r_mode, n_mode;
    logic [7:0] r_count, n_count;
    logic [7:0] r_xor, n_xor;
    logic [7:0] r_recent [3];
    logic [7:0] n_recent [3];
    logic       r_tag_match, n_tag_match;

    logic       fire;
    logic [7:0] limit;
    logic [7:0] want;
    logic [7:0] cc;
    logic [7:0] rc;
    logic [7:0] hd_hi;
    logic [7:0] hd_lo;

    assign fire      = i_tok_valid && !i_res_full;
    assign o_tok_pop = fire;
    assign limit     = (i_max_length < C_MAX_LEN) ? i_max_length : C_MAX_LEN;
    assign hd_hi     = hex_digit(r_recent[1]);
    assign hd_lo     = hex_digit(r_recent[0]);
    assign cc        = r_xor ^ r_recent[0] ^ r_recent[1] ^ r_recent[2];
    assign rc        = {hd_hi[3:0], 4'h0} | hd_lo;

    always_comb begin
        unique case (r_count[2:0])
            3'd1:    want = i_sentence_tag[39:32];
            3'd2:    want = i_sentence_tag[31:24];
            3'd3:    want = i_sentence_tag[23:16];
            3'd4:    want = i_sentence_tag[15:8];
            3'd5:    want = i_sentence_tag[7:0];
            default: want = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_WAIT_DOLLAR;
            r_count     <= '0;
            r_xor       <= '0;
            r_recent[0] <= '0;
            r_recent[1] <= '0;
            r_recent[2] <= '0;
            r_tag_match <= 1'b1;
        end else if (fire) begin
            r_mode      <= n_mode;
            r_count     <= n_count;
            r_xor       <= n_xor;
            r_recent[0] <= n_recent[0];
            r_recent[1] <= n_recent[1];
            r_recent[2] <= n_recent[2];
            r_tag_match <= n_tag_match;
        end
    end

    always_comb begin
        n_mode      = r_mode;
        n_count     = r_count;
        n_xor       = r_xor;
        n_recent[0] = r_recent[0];
        n_recent[1] = r_recent[1];
        n_recent[2] = r_recent[2];
        n_tag_match = r_tag_match;
        o_res_push  = 1'b0;
        o_res.status            = ST_OVERFLOW;
        o_res.sentence_length   = r_count;
        o_res.computed_checksum = '0;
        o_res.received_checksum = '0;

        unique case (r_mode)
            MODE_COLLECT: begin
                if (i_tok.is_cr) begin
                    n_mode = MODE_WAIT_LF;
                end else if (r_count >= limit) begin
                    // drop the sentence
                    o_res_push   = fire;
                    o_res.status = ST_OVERFLOW;
                end else begin
                    if (r_count >= 8'd1 && r_count <= 8'd5 && i_tok.data != want) begin
                        n_tag_match = 1'b0;
                    end
                    n_xor       = r_xor ^ i_tok.data;
                    n_recent[2] = r_recent[1];
                    n_recent[1] = r_recent[0];
                    n_recent[0] = i_tok.data;
                    n_count     = r_count + 8'd1;
                end
            end
            MODE_WAIT_LF: begin
                o_res_push = fire;
                if (!i_tok.is_lf) begin
                    o_res.status = ST_MISSING_LF;
                end else if (r_count < C_MIN_LEN) begin
                    o_res.status = ST_TOO_SHORT;
                end else begin
                    o_res.computed_checksum = cc;
                    o_res.received_checksum = rc;
                    if (cc != rc) begin
                        o_res.status = ST_CHECKSUM_ERROR;
                    end else if (!r_tag_match || r_count < C_TAG_LEN) begin
                        o_res.status = ST_NOT_RMC;
                    end else begin
                        o_res.status = ST_RMC_OK;
                    end
                end
            end
            default: begin
                n_mode = MODE_WAIT_DOLLAR;
                if (i_tok.is_dollar) begin
                    n_mode = MODE_COLLECT;
                    n_count = 8'd1;
                end
            end
        endcase

        // every emitted result returns to idle
        if (o_res_push) begin
            n_mode      = MODE_WAIT_DOLLAR;
            n_count     = '0;
            n_xor       = '0;
            n_recent[0] = '0;
            n_recent[1] = '0;
            n_recent[2] = '0;
            n_tag_match = 1'b1;
        end
        if (r_mode != MODE_COLLECT && r_mode != MODE_WAIT_LF && i_tok.is_dollar) begin
            n_xor       = '0;
            n_recent[0] = '0;
            n_recent[1] = '0;
            n_recent[2] = '0;
            n_tag_match = 1'b1;
        end
    end

endmodule

>>> hw/rtl/nmea_sentence_framer_checker_top.sv
// Path: a closing byte goes from the token queue through the framer, whose result is written
//   to the result queue (empty falls); one byte is framed per cycle while that queue has room.
// Throughput: one byte per cycle, sustained while results are popped; two 4-entry queues
//   decouple the byte input, the framer and the result output.
// Reset: synchronous, active low; empties both queues, returns the framer to waiting for
//   '$' and loads sentence_tag with "GPRMC" and max_length with 128.
module nmea_sentence_framer_checker_top import nsfc_pkg::*; #(
    parameter int IN_DEPTH  = 4,
    parameter int OUT_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input queue side
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic [7:0]  o_sentence_length,
    output logic [7:0]  o_computed_checksum,
    output logic [7:0]  o_received_checksum,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [39:0] r_sentence_tag;
    logic [7:0]  r_max_length;
    logic        cfg_wr;
    t_reg_index  reg_sel;

    logic        tok_push;
    t_token      tok_in;
    t_token      tok_out;
    logic        tok_empty;
    logic        tok_pop;
    logic        res_push;
    logic        res_full;
    t_result     res_in;
    t_result     res_out;

    // Configuration: registers at byte addresses 0 and 8; pready is always high, so accesses never wait.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = t_reg_index'(paddr[3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sentence_tag <= C_TAG_RESET;
            r_max_length   <= C_MAXLEN_RESET;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_SENTENCE_TAG: r_sentence_tag <= pwdata[39:0];
                REG_MAX_LENGTH:   r_max_length   <= pwdata[7:0];
                default:          r_max_length   <= r_max_length;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_SENTENCE_TAG: prdata = {24'h0, r_sentence_tag};
            REG_MAX_LENGTH:   prdata = {56'h0, r_max_length};
            default:          prdata = '0;
        endcase
    end

    // Front end: classify each request and hold it in the token queue.
    nsfc_front u_front (
        .i_push       (push),
        .i_rx_byte    (i_rx_byte),
        .i_queue_full (full),
        .o_queue_push (tok_push),
        .o_token      (tok_in)
    );

    nsfc_fifo #(
        .WIDTH ($bits(t_token)),
        .DEPTH (IN_DEPTH)
    ) u_tok_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (tok_push),
        .i_data  (tok_in),
        .o_full  (full),
        .i_pop   (tok_pop),
        .o_data  (tok_out),
        .o_empty (tok_empty)
    );

    // Back end: frame the sentence; advance only when the result queue has room.
    nsfc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tok_valid    (!tok_empty),
        .i_tok          (tok_out),
        .o_tok_pop      (tok_pop),
        .i_res_full     (res_full),
        .o_res_push     (res_push),
        .o_res          (res_in),
        .i_sentence_tag (r_sentence_tag),
        .i_max_length   (r_max_length)
    );

    // Result queue: the oldest result sits on the ports while empty is low.
    nsfc_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_status            = res_out.status;
    assign o_sentence_length   = res_out.sentence_length;
    assign o_computed_checksum = res_out.computed_checksum;
    assign o_received_checksum = res_out.received_checksum;

`ifndef ASSERT_OFF
    // A dropped or malformed sentence carries no checksums.
    a_no_chk_on_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_status == ST_OVERFLOW || o_status == ST_MISSING_LF ||
                    o_status == ST_TOO_SHORT))
        |-> (o_computed_checksum == 8'h0 && o_received_checksum == 8'h0))
        else $error("drop status with non-zero checksum");

    // A good sentence has matching checksums and room for the tag.
    a_ok_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == ST_RMC_OK)
        |-> (o_computed_checksum == o_received_checksum && o_sentence_length >= C_TAG_LEN))
        else $error("rmc_ok with inconsistent fields");

    // The stored length never passes the hard limit.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_sentence_length <= C_MAX_LEN))
        else $error("sentence length beyond limit");
`endif

endmodule

>>> tb/nmea_sentence_framer_checker_top_test.sv
`timescale 1ns / 1ps

module nmea_sentence_framer_checker_top_test;
    import nsfc_pkg::*;

    localparam int QUIET_LIMIT   = 4000;  // cycles with no handshake at all before giving up
    localparam int SETTLE_CYCLES = 16;    // input queue, framer and output queue drain well inside this

    localparam logic [7:0] CHAR_STAR = 8'h2A;
    localparam logic [7:0] PRINT_LO  = 8'h20;
    localparam logic [7:0] PRINT_HI  = 8'h7E;

    // Kinds of traffic the stimulus builds; the largest share are well-formed sentences with random content
    typedef enum {
        SHAPE_GOOD,
        SHAPE_BAD_SUM,
        SHAPE_FOREIGN_TAG,
        SHAPE_NO_LF,
        SHAPE_STUB,
        SHAPE_NOISE,
        SHAPE_LONG
    } t_shape;

    // Block ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  o_status;
    logic [7:0]  o_sentence_length;
    logic [7:0]  o_computed_checksum;
    logic [7:0]  o_received_checksum;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'h0;
    logic [63:0] pwdata = 64'h0;
    logic [63:0] prdata;
    logic        pready;

    // Byte requests waiting for the driver, and reports the framer owes us, oldest first
    logic [7:0] rx_backlog[$];
    t_result    due_reports[$];

    // Our own copy of the framer state and its registers
    t_mode       fr_mode;
    logic [7:0]  fr_count;
    logic [7:0]  fr_xor;
    logic [7:0]  fr_tail[3];   // [0] is the newest stored byte
    bit          fr_tag_ok;
    logic [39:0] cfg_tag;
    logic [7:0]  cfg_max_len;

    // Handshake bookkeeping shared between the clocked blocks
    bit byte_taken = 1'b0;
    int quiet_cycles = 0;
    int err_count = 0;
    int bytes_staged = 0;
    int idle_pct = 0;
    int stall_pct = 0;

    nmea_sentence_framer_checker_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .push                (push),
        .full                (full),
        .i_rx_byte           (i_rx_byte),
        .empty               (empty),
        .pop                 (pop),
        .o_status            (o_status),
        .o_sentence_length   (o_sentence_length),
        .o_computed_checksum (o_computed_checksum),
        .o_received_checksum (o_received_checksum),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Sentence prediction
    // ------------------------------------------------------------------

    // Hex digit value as the framer decodes it: digits and below map from '0', letters fold
    // to upper case and map from 'A' plus ten, everything wraps at 8 bits.
    function automatic logic [7:0] nibble_value(input logic [7:0] ch);
        logic [7:0] folded;
        if (ch <= C_CHAR_NINE) begin
            return ch - C_CHAR_ZERO;
        end
        folded = (ch >= C_CHAR_LOWER_A && ch <= C_CHAR_LOWER_Z) ? ch - C_CASE_OFFSET : ch;
        return folded - C_CHAR_UPPER_A + C_HEX_TEN;
    endfunction

    // Drop any partial sentence and wait for the next dollar
    task automatic clear_frame();
        fr_mode   = MODE_WAIT_DOLLAR;
        fr_count  = 8'd0;
        fr_xor    = 8'd0;
        fr_tail[0] = 8'd0;
        fr_tail[1] = 8'd0;
        fr_tail[2] = 8'd0;
        fr_tag_ok = 1'b1;
    endtask

    // Advance the framer by one accepted byte; queue a report when a sentence closes
    task automatic frame_byte(input logic [7:0] b);
        t_result    rep;
        logic [7:0] cap;
        bit         closed;
        int         sh;
        closed = 1'b0;
        rep = '0;
        case (fr_mode)
            MODE_COLLECT: begin
                cap = (cfg_max_len < C_MAX_LEN) ? cfg_max_len : C_MAX_LEN;
                if (b == C_CHAR_CR) begin
                    fr_mode = MODE_WAIT_LF;
                end else if (fr_count >= cap) begin
                    // the byte that overflows is swallowed, not taken as a new dollar
                    rep.status = ST_OVERFLOW;
                    rep.sentence_length = fr_count;
                    closed = 1'b1;
                end else begin
                    if (fr_count >= 1 && fr_count <= 5) begin
                        sh = 8 * (5 - int'(fr_count));
                        if (b != cfg_tag[sh +: 8]) begin
                            fr_tag_ok = 1'b0;
                        end
                    end
                    fr_xor = fr_xor ^ b;
                    fr_tail[2] = fr_tail[1];
                    fr_tail[1] = fr_tail[0];
                    fr_tail[0] = b;
                    fr_count = fr_count + 8'd1;
                end
            end
            MODE_WAIT_LF: begin
                closed = 1'b1;
                rep.sentence_length = fr_count;
                if (b != C_CHAR_LF) begin
                    rep.status = ST_MISSING_LF;
                end else if (fr_count < C_MIN_LEN) begin
                    rep.status = ST_TOO_SHORT;
                end else begin
                    // the star and the two hex digits are the last three stored bytes
                    rep.computed_checksum = fr_xor ^ fr_tail[0] ^ fr_tail[1] ^ fr_tail[2];
                    rep.received_checksum = (nibble_value(fr_tail[1]) << 4)
                                          | nibble_value(fr_tail[0]);
                    if (rep.computed_checksum != rep.received_checksum) begin
                        rep.status = ST_CHECKSUM_ERROR;
                    end else if (!fr_tag_ok || fr_count < C_TAG_LEN) begin
                        rep.status = ST_NOT_RMC;
                    end else begin
                        rep.status = ST_RMC_OK;
                    end
                end
            end
            default: begin
                if (b == C_CHAR_DOLLAR) begin
                    clear_frame();
                    fr_mode = MODE_COLLECT;
                    fr_count = 8'd1;
                end else begin
                    fr_mode = MODE_WAIT_DOLLAR;
                end
            end
        endcase
        if (closed) begin
            due_reports.push_back(rep);
            clear_frame();
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
        end
    endtask

    // Sample every handshake on the rising edge: configuration, byte requests and reports
    always @(posedge i_clk) begin : watch_ports
        t_result want;
        bit      moved;
        moved = 1'b0;
        byte_taken = 1'b0;
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_index'(paddr[3]))
                    REG_SENTENCE_TAG: cfg_tag = pwdata[39:0];
                    REG_MAX_LENGTH:   cfg_max_len = pwdata[7:0];
                    default: ;
                endcase
                moved = 1'b1;
            end
            if (push && !full) begin
                frame_byte(i_rx_byte);
                byte_taken = 1'b1;
                moved = 1'b1;
            end
            if (pop && !empty) begin
                moved = 1'b1;
                if (due_reports.size() == 0) begin
                    report_mismatch($sformatf("unexpected report, status %0d length %0d",
                                              o_status, o_sentence_length));
                end else begin
                    want = due_reports.pop_front();
                    check_field("status", 8'(o_status), 8'(want.status));
                    check_field("sentence_length", o_sentence_length, want.sentence_length);
                    check_field("computed_checksum", o_computed_checksum,
                                want.computed_checksum);
                    check_field("received_checksum", o_received_checksum,
                                want.received_checksum);
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Present the oldest waiting byte, hold a request until it is taken, and idle or stall
    // at the rates of the current phase. Everything changes on the falling edge.
    always @(negedge i_clk) begin : drive_ports
        logic       next_push;
        logic [7:0] next_byte;
        next_push = 1'b0;
        next_byte = i_rx_byte;
        if (i_rst_n) begin
            if (byte_taken) begin
                void'(rx_backlog.pop_front());
            end
            if (push && !byte_taken) begin
                next_push = 1'b1;
            end else if (rx_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
                next_push = 1'b1;
                next_byte = rx_backlog[0];
            end
            pop <= ($urandom_range(99) >= stall_pct);
        end else begin
            pop <= 1'b0;
        end
        push <= next_push;
        i_rx_byte <= next_byte;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic stage(input logic [7:0] b);
        rx_backlog.push_back(b);
        bytes_staged++;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10) begin
            return C_CHAR_ZERO + 8'(n);
        end
        return (lower ? C_CHAR_LOWER_A : C_CHAR_UPPER_A) + 8'(n) - C_HEX_TEN;
    endfunction

    // Build one stretch of traffic of the given kind and append it to the backlog
    task automatic queue_sentence(input t_shape shape);
        logic [7:0] sum;
        logic [7:0] c;
        int         body_len;
        int         cap;
        bit         lower;
        if (shape == SHAPE_NOISE) begin
            // raw bytes of any value: dollars, CR and LF included
            repeat ($urandom_range(1, 6)) stage(8'($urandom_range(255)));
        end else if (shape == SHAPE_STUB) begin
            // one to four stored bytes: too short, or too short to carry the tag
            stage(C_CHAR_DOLLAR);
            repeat ($urandom_range(0, 3)) stage(8'($urandom_range(PRINT_LO, PRINT_HI)));
            stage(C_CHAR_CR);
            stage(C_CHAR_LF);
        end else begin
            stage(C_CHAR_DOLLAR);
            sum = 8'd0;
            for (int i = 0; i < 5; i++) begin
                c = (shape == SHAPE_FOREIGN_TAG) ? 8'($urandom_range(PRINT_LO, PRINT_HI))
                                                 : cfg_tag[8 * (4 - i) +: 8];
                stage(c);
                sum ^= c;
            end
            cap = (cfg_max_len < C_MAX_LEN) ? int'(cfg_max_len) : int'(C_MAX_LEN);
            if (shape == SHAPE_LONG) begin
                // straddle the length limit: some fit exactly, some overflow
                body_len = cap - 9 + int'($urandom_range(6)) - 3;
                if (body_len < 0) begin
                    body_len = 0;
                end
            end else begin
                body_len = $urandom_range(10);
            end
            repeat (body_len) begin
                if ($urandom_range(9) < 8) begin
                    c = 8'($urandom_range(PRINT_LO, PRINT_HI));
                end else begin
                    do c = 8'($urandom_range(255)); while (c == C_CHAR_CR);
                end
                stage(c);
                sum ^= c;
            end
            if (shape == SHAPE_BAD_SUM) begin
                sum ^= 8'($urandom_range(1, 255));
            end
            lower = ($urandom_range(3) == 0);
            stage(CHAR_STAR);
            stage(hex_char(sum[7:4], lower));
            stage(hex_char(sum[3:0], lower));
            stage(C_CHAR_CR);
            if (shape == SHAPE_NO_LF) begin
                do c = 8'($urandom_range(255)); while (c == C_CHAR_LF);
                stage(c);
            end else begin
                stage(C_CHAR_LF);
            end
        end
    endtask

    // Register write: setup cycle, then access cycle until pready is seen high
    task automatic write_reg(input t_reg_index idx, input logic [63:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One phase: configure while idle, feed the traffic, then drain everything so the
    // next phase may write the registers again.
    task automatic run_phase(input logic [39:0] tag, input logic [7:0] max_len,
                             input int idle, input int stall, input int budget,
                             input bit with_directed);
        int      start;
        int      r;
        t_shape  shape;
        write_reg(REG_SENTENCE_TAG, {24'h0, tag});
        write_reg(REG_MAX_LENGTH, {56'h0, max_len});
        idle_pct = idle;
        stall_pct = stall;
        if (with_directed) begin
            // a clean tagged sentence, a bare dollar, a tagless one with a zero checksum,
            // a CR followed by something other than LF, then the byte extremes in idle
            string text;
            text = "$GPRMC*4B\r\n$\r\n$*00\r\n$x\rQ";
            for (int i = 0; i < text.len(); i++) begin
                stage(text[i]);
            end
            stage(8'h00);
            stage(8'hFF);
        end
        start = bytes_staged;
        while (bytes_staged - start < budget) begin
            r = $urandom_range(99);
            if (r < 44)      shape = SHAPE_GOOD;
            else if (r < 56) shape = SHAPE_BAD_SUM;
            else if (r < 66) shape = SHAPE_FOREIGN_TAG;
            else if (r < 74) shape = SHAPE_NO_LF;
            else if (r < 83) shape = SHAPE_STUB;
            else if (r < 98) shape = SHAPE_NOISE;
            else             shape = SHAPE_LONG;
            queue_sentence(shape);
        end
        while (rx_backlog.size() != 0 || push) @(posedge i_clk);
        while (due_reports.size() != 0) @(posedge i_clk);
        // bytes that close nothing may still sit in the block's queue or framer
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------

    initial begin : run_all
        logic [39:0] odd_tag;
        odd_tag = '0;
        for (int i = 0; i < 5; i++) begin
            odd_tag = {odd_tag[31:0], 8'($urandom_range(PRINT_LO, PRINT_HI))};
        end
        cfg_tag = C_TAG_RESET;
        cfg_max_len = C_MAXLEN_RESET;
        clear_frame();

        // hold reset, then release it on a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_phase(C_TAG_RESET, C_MAXLEN_RESET, 0, 0, 260, 1'b1);
        run_phase(odd_tag, 8'd255, 64, 0, 260, 1'b0);
        run_phase(40'h4750474741, 8'd4, 0, 64, 140, 1'b0);
        run_phase(40'hFFFFFFFFFF, C_MAX_LEN, 13, 13, 260, 1'b0);
        run_phase(C_TAG_RESET, 8'd1, 0, 0, 80, 1'b0);
        run_phase(40'h0000000000, 8'd20, 64, 0, 160, 1'b0);

        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Give up when no request of any kind has moved for too long
    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Watchdog: no handshake for %0d cycles, %0d reports outstanding",
                 QUIET_LIMIT, due_reports.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> nmea_sentence_framer_checker_top.f
hw/rtl/nsfc_pkg.sv
hw/rtl/nsfc_fifo.sv
hw/rtl/nsfc_front.sv
hw/rtl/nsfc_back.sv
hw/rtl/nmea_sentence_framer_checker_top.sv
tb/nmea_sentence_framer_checker_top_test.sv
